[src/mpq_pkg.sv]
// Shared types and constants for the min priority queue.
// Used by the channel interfaces and the core.
package mpq_pkg;

  // Port widths of the channel words
  localparam int KEY_PORT_W    = 32;
  localparam int MIN_KEY_W     = 32;
  localparam int COUNT_PORT_W  = 7;
  localparam int STATUS_W      = 2;

  // Operation codes carried in cmd
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } mpq_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_LOAD,
    ST_UP_EVAL,
    ST_DN_EVAL,
    ST_FINISH
  } mpq_state_t;

endpackage

[src/mpq_in_if.sv]
// Request channel of the min priority queue: one operation per word.
// Depends on mpq_pkg for the key width.
interface mpq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [mpq_pkg::KEY_PORT_W-1:0]  key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

[src/mpq_out_if.sv]
// Response channel of the min priority queue: one result per word.
// Depends on mpq_pkg for field widths and the status type.
interface mpq_out_if;
  logic                              valid;
  logic                              ready;
  logic [mpq_pkg::MIN_KEY_W-1:0]     min_key;
  logic [mpq_pkg::COUNT_PORT_W-1:0]  count;
  logic                              is_empty;
  mpq_pkg::mpq_status_t              status;

  modport source (output valid, min_key, count, is_empty, status, input ready);
  modport sink   (input valid, min_key, count, is_empty, status, output ready);
endinterface

[src/mpq_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies; contents are not reset.
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[src/min_priority_queue_core.sv]
// Min priority queue held as a binary min-heap in one dual-read RAM.
// Push: ST_UP_EVAL climbs k levels, then ST_FINISH; one sift level per cycle.
// Pop: ST_POP_LOAD, then ST_DN_EVAL descends k levels (k <= log2(CAPACITY)), then
// ST_FINISH; popping the last key skips ST_DN_EVAL. Rejected push or pop: straight to
// ST_FINISH. Next word accepted after the result is registered, later while one waits.
// Reset (rst, synchronous) empties the queue; heap storage is not cleared.
module min_priority_queue_core #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mpq_in_if.sink    req,
  mpq_out_if.source rsp
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CW     = ADDR_W + 2;

  // Registers
  mpq_pkg::mpq_state_t  state, state_next;
  logic [CNT_W-1:0]     element_count, element_count_next;
  logic [ADDR_W-1:0]    pos, pos_next;
  logic [KEY_WIDTH-1:0] val, val_next;
  logic [KEY_WIDTH-1:0] root_key, root_key_next;
  mpq_pkg::mpq_status_t status_q, status_q_next;
  logic                 out_valid;
  logic [mpq_pkg::MIN_KEY_W-1:0]    out_min_key;
  logic [mpq_pkg::COUNT_PORT_W-1:0] out_count;
  logic                 out_is_empty;
  mpq_pkg::mpq_status_t out_status;

  // RAM ports
  logic                 we;
  logic [ADDR_W-1:0]    waddr, raddr_a, raddr_b;
  logic [KEY_WIDTH-1:0] wdata, rd_a, rd_b;

  mpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_heap (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Handshake
  logic req_acc, out_load;
  assign req.ready = (state == mpq_pkg::ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign out_load  = (state == mpq_pkg::ST_FINISH) && (!out_valid || rsp.ready);

  // Key taken to the stored width
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_in;
  assign key_ext = 64'(req.key);
  assign key_in  = key_ext[KEY_WIDTH-1:0];

  logic is_full, is_zero;
  assign is_full = (element_count == CNT_W'(CAPACITY));
  assign is_zero = (element_count == '0);

  // Sift-up compare: parent of pos and its parent
  logic [ADDR_W-1:0] par, par_par, push_par, last_addr;
  logic              up_go;
  assign par       = (pos - 1'b1) >> 1;
  assign par_par   = (par - 1'b1) >> 1;
  assign push_par  = ADDR_W'((element_count - 1'b1) >> 1);
  assign last_addr = ADDR_W'(element_count - 1'b1);
  assign up_go     = (pos != '0) && (val < rd_a);

  // Sift-down compare over both children of pos
  logic [CW-1:0]        n_cw, l_idx, r_idx, best_idx, nl_idx, nr_idx;
  logic                 l_ok, r_ok, dn_go;
  logic [KEY_WIDTH-1:0] l_best, best_val;
  assign n_cw     = CW'(element_count);
  assign l_idx    = {1'b0, pos, 1'b1};
  assign r_idx    = l_idx + 1'b1;
  assign l_ok     = (l_idx < n_cw) && (rd_a < val);
  assign l_best   = l_ok ? rd_a : val;
  assign r_ok     = (r_idx < n_cw) && (rd_b < l_best);
  assign dn_go    = l_ok || r_ok;
  assign best_idx = r_ok ? r_idx : l_idx;
  assign best_val = r_ok ? rd_b : rd_a;
  assign nl_idx   = {best_idx[CW-2:0], 1'b1};
  assign nr_idx   = nl_idx + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mpq_pkg::ST_IDLE: begin
        if (req_acc) begin
          if (req.cmd == mpq_pkg::CMD_PUSH) begin
            state_next = is_full ? mpq_pkg::ST_FINISH : mpq_pkg::ST_UP_EVAL;
          end else begin
            state_next = is_zero ? mpq_pkg::ST_FINISH : mpq_pkg::ST_POP_LOAD;
          end
        end
      end
      mpq_pkg::ST_POP_LOAD: begin
        state_next = is_zero ? mpq_pkg::ST_FINISH : mpq_pkg::ST_DN_EVAL;
      end
      mpq_pkg::ST_UP_EVAL: begin
        if (!up_go) state_next = mpq_pkg::ST_FINISH;
      end
      mpq_pkg::ST_DN_EVAL: begin
        if (!dn_go) state_next = mpq_pkg::ST_FINISH;
      end
      mpq_pkg::ST_FINISH: begin
        if (out_load) state_next = mpq_pkg::ST_IDLE;
      end
      default: state_next = mpq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    element_count_next = element_count;
    pos_next           = pos;
    val_next           = val;
    status_q_next      = status_q;
    we                 = 1'b0;
    waddr              = pos;
    wdata              = val;
    raddr_a            = par_par;
    raddr_b            = par_par;
    case (state)
      mpq_pkg::ST_IDLE: begin
        if (req_acc) begin
          status_q_next = mpq_pkg::STATUS_OK;
          if (req.cmd == mpq_pkg::CMD_PUSH) begin
            if (is_full) begin
              status_q_next = mpq_pkg::STATUS_FULL;
            end else begin
              // open a hole at the tail and fetch its parent
              pos_next           = ADDR_W'(element_count);
              val_next           = key_in;
              element_count_next = element_count + 1'b1;
              raddr_a            = push_par;
            end
          end else begin
            if (is_zero) begin
              status_q_next = mpq_pkg::STATUS_EMPTY;
            end else begin
              // fetch the last entry, it moves to the root
              element_count_next = element_count - 1'b1;
              raddr_a            = last_addr;
            end
          end
        end
      end
      mpq_pkg::ST_POP_LOAD: begin
        val_next = rd_a;
        pos_next = '0;
        raddr_a  = ADDR_W'(1);
        raddr_b  = ADDR_W'(2);
      end
      mpq_pkg::ST_UP_EVAL: begin
        we = 1'b1;
        if (up_go) begin
          // move parent down, climb
          wdata    = rd_a;
          pos_next = par;
          raddr_a  = par_par;
        end
      end
      mpq_pkg::ST_DN_EVAL: begin
        we = 1'b1;
        if (dn_go) begin
          // move smaller child up, descend
          wdata    = best_val;
          pos_next = best_idx[ADDR_W-1:0];
          raddr_a  = nl_idx[ADDR_W-1:0];
          raddr_b  = nr_idx[ADDR_W-1:0];
        end
      end
      mpq_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Track the root whenever entry zero is written
  assign root_key_next = (we && (waddr == '0)) ? wdata : root_key;

  // Result word fields
  logic [63:0] root_ext;
  logic [15:0] cnt_ext;
  assign root_ext = 64'(root_key);
  assign cnt_ext  = 16'(element_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mpq_pkg::ST_IDLE;
      element_count <= '0;
      out_valid     <= 1'b0;
      status_q      <= mpq_pkg::STATUS_OK;
    end else begin
      state         <= state_next;
      element_count <= element_count_next;
      status_q      <= status_q_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    val      <= val_next;
    root_key <= root_key_next;
    if (out_load) begin
      out_min_key  <= is_zero ? '0 : root_ext[mpq_pkg::MIN_KEY_W-1:0];
      out_count    <= cnt_ext[mpq_pkg::COUNT_PORT_W-1:0];
      out_is_empty <= is_zero;
      out_status   <= status_q;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.min_key  = out_min_key;
  assign rsp.count    = out_count;
  assign rsp.is_empty = out_is_empty;
  assign rsp.status   = out_status;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mpq_pkg::ST_IDLE) |-> !we)
    else $error("heap written while idle");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.cmd == mpq_pkg::CMD_PUSH && is_full) |=>
      (element_count == $past(element_count)) && (status_q == mpq_pkg::STATUS_FULL))
    else $error("rejected push changed the count");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.cmd == mpq_pkg::CMD_POP && !is_zero) |=>
      (element_count == $past(element_count) - 1'b1))
    else $error("pop did not drop one entry");

endmodule

[dv/tb_min_priority_queue_core.sv]
// Testbench for min_priority_queue_core: push and pop words with random gaps and stalls.
// Results are checked against a sorted-list predictor of the queue contents.
// Depends on mpq_pkg, mpq_in_if, mpq_out_if and the core itself.
module tb_min_priority_queue_core;

  localparam int QUEUE_DEPTH  = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int CNT_W        = mpq_pkg::COUNT_PORT_W;

  typedef logic [mpq_pkg::KEY_PORT_W-1:0] key_t;

  typedef struct packed {
    logic [mpq_pkg::MIN_KEY_W-1:0]    min_key;
    logic [mpq_pkg::COUNT_PORT_W-1:0] count;
    logic                             is_empty;
    mpq_pkg::mpq_status_t             status;
  } queue_view_t;

  logic clk;
  logic rst;

  mpq_in_if  req_ch ();
  mpq_out_if rsp_ch ();

  min_priority_queue_core #(
    .CAPACITY  (QUEUE_DEPTH),
    .KEY_WIDTH (mpq_pkg::KEY_PORT_W)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted contents, kept in ascending order; duplicates stay as separate entries
  key_t        held_keys_sorted[$];
  queue_view_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rsp_hold_left = 0;
  int err_count     = 0;
  int words_sent    = 0;
  int full_rejects  = 0;
  int empty_pops    = 0;
  int peak_depth    = 0;
  int cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Apply one operation to the predicted contents and return the view after it
  function automatic queue_view_t predict_queue_op(logic op, key_t key);
    queue_view_t view;
    int          pos;
    view.status = mpq_pkg::STATUS_OK;
    if (op == mpq_pkg::CMD_PUSH) begin
      if (held_keys_sorted.size() >= QUEUE_DEPTH) begin
        view.status = mpq_pkg::STATUS_FULL;
        full_rejects++;
      end else begin
        pos = held_keys_sorted.size();
        for (int i = 0; i < held_keys_sorted.size(); i++) begin
          if (held_keys_sorted[i] > key) begin
            pos = i;
            break;
          end
        end
        held_keys_sorted.insert(pos, key);
      end
    end else begin
      if (held_keys_sorted.size() == 0) begin
        view.status = mpq_pkg::STATUS_EMPTY;
        empty_pops++;
      end else begin
        void'(held_keys_sorted.pop_front());
      end
    end
    if (held_keys_sorted.size() > peak_depth)
      peak_depth = held_keys_sorted.size();
    view.count    = CNT_W'(held_keys_sorted.size());
    view.is_empty = (held_keys_sorted.size() == 0);
    view.min_key  = view.is_empty ? '0 : held_keys_sorted[0];
    return view;
  endfunction

  // Offer one word, idling first at the current rate, and log the expected result on accept
  task automatic send_op(logic op, key_t key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= op;
    req_ch.key   <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_queue_op(op, key));
    words_sent++;
  endtask

  task automatic report_mismatch(string field, longint unsigned exp_v, longint unsigned act_v);
    $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
    err_count++;
  endtask

  // Check each result word against the oldest expectation, then drive ready
  initial begin
    queue_view_t exp_view;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("Result word with no expectation waiting: min_key %0d count %0d",
                 rsp_ch.min_key, rsp_ch.count);
          err_count++;
        end else begin
          exp_view = pending_results.pop_front();
          if (rsp_ch.min_key !== exp_view.min_key)
            report_mismatch("min_key", exp_view.min_key, rsp_ch.min_key);
          if (rsp_ch.count !== exp_view.count)
            report_mismatch("count", exp_view.count, rsp_ch.count);
          if (rsp_ch.is_empty !== exp_view.is_empty)
            report_mismatch("is_empty", exp_view.is_empty, rsp_ch.is_empty);
          if (rsp_ch.status !== exp_view.status)
            report_mismatch("status", exp_view.status, rsp_ch.status);
        end
      end
      // Hold off for a long stretch when asked, otherwise stall at random
      if (rsp_hold_left > 0) begin
        rsp_ch.ready  <= 1'b0;
        rsp_hold_left <= rsp_hold_left - 1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Mix full-range keys, a small pool for duplicates and the bit extremes
  function automatic key_t pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom_range(1) ? '1 : '0;
      2: return {1'($urandom_range(1)), 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Extremes of the key, duplicates, and pops on an empty queue
  task automatic test_directed_ops();
    send_op(mpq_pkg::CMD_POP, 32'h0);
    send_op(mpq_pkg::CMD_PUSH, 32'hFFFF_FFFF);
    send_op(mpq_pkg::CMD_PUSH, 32'h0000_0000);
    send_op(mpq_pkg::CMD_PUSH, 32'h0000_0000);
    send_op(mpq_pkg::CMD_POP, 32'hFFFF_FFFF);
    send_op(mpq_pkg::CMD_POP, 32'h0);
    send_op(mpq_pkg::CMD_POP, 32'h0);
    send_op(mpq_pkg::CMD_POP, 32'h0);
    send_op(mpq_pkg::CMD_PUSH, 32'h8000_0000);
    send_op(mpq_pkg::CMD_PUSH, 32'h7FFF_FFFF);
    send_op(mpq_pkg::CMD_PUSH, 32'h0000_0001);
    send_op(mpq_pkg::CMD_PUSH, 32'hFFFF_FFFE);
    send_op(mpq_pkg::CMD_PUSH, 32'h5555_5555);
    send_op(mpq_pkg::CMD_PUSH, 32'hAAAA_AAAA);
    repeat (6) send_op(mpq_pkg::CMD_POP, 32'h0);
    send_op(mpq_pkg::CMD_POP, 32'hFFFF_FFFF);
  endtask

  // Fill past capacity, drain past empty, and mixed bursts of random bias
  task automatic test_random_traffic(int num_words);
    int target;
    int push_pct;
    target = words_sent + num_words;
    while (words_sent < target) begin
      case ($urandom_range(9))
        0, 1: begin
          repeat (QUEUE_DEPTH - held_keys_sorted.size() + $urandom_range(1, 3))
            send_op(mpq_pkg::CMD_PUSH, pick_key());
        end
        2, 3: begin
          repeat (held_keys_sorted.size() + $urandom_range(1, 2))
            send_op(mpq_pkg::CMD_POP, $urandom);
        end
        default: begin
          push_pct = $urandom_range(30, 70);
          repeat ($urandom_range(8, 24))
            send_op(($urandom_range(99) < push_pct) ? mpq_pkg::CMD_PUSH : mpq_pkg::CMD_POP,
                    pick_key());
        end
      endcase
    end
  endtask

  // Block the result side for a long stretch while words keep coming
  task automatic test_output_backpressure();
    rsp_hold_left = 300;
    repeat (12)
      send_op($urandom_range(3) == 0 ? mpq_pkg::CMD_POP : mpq_pkg::CMD_PUSH, pick_key());
  endtask

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd   <= mpq_pkg::CMD_PUSH;
    req_ch.key   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 67;
    test_directed_ops();
    test_random_traffic(430);

    send_idle_pct = 67;
    recv_idle_pct = 35;
    test_random_traffic(430);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(430);
    req_ch.valid <= 1'b0;

    // Drain, then keep watching for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words in three idling phases plus a long result stall.", words_sent);
    $display("Refused %0d pushes when full, ignored %0d pops when empty, peak depth %0d.",
             full_rejects, empty_pops, peak_depth);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
